// ===== hdl/dpcr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and arithmetic helpers for the disc pair collision resolver.
// No dependencies; used by dpcr_sqrt and disc_pair_collision_resolver.
package dpcr_pkg;

	localparam int FIELD_W  = 21;
	localparam int RAD_W    = 16;
	localparam int MASS_W   = 16;
	localparam int GAP_W    = 16;
	localparam int DIFF_W   = FIELD_W + 1;
	localparam int RSUM_W   = RAD_W + 1;
	localparam int RSG_W    = RAD_W + 2;
	localparam int SQR_W    = 2 * DIFF_W;
	localparam int D2_W     = SQR_W;
	localparam int RSQ_W    = 2 * RSUM_W;

	localparam int RAD_SCALE = 16;
	localparam int SQ_IN_W   = D2_W + RAD_SCALE;
	localparam int ROOT_W    = SQ_IN_W / 2;
	localparam int SQ_REM_W  = SQ_IN_W + 2;

	localparam int NRM_SHIFT = 24;
	localparam int NQ_W      = 17;
	localparam int NRM_W     = NQ_W + 1;
	localparam int NREM_W    = 48;

	localparam int PUSH_FRAC  = 8;
	localparam int PUSH_W     = 33;
	localparam int PUSH_SHIFT = 25;
	localparam int PN_W       = PUSH_W + NRM_W;
	localparam int SHIFT_W    = 26;
	localparam int RN_W       = DIFF_W + NRM_W;
	localparam int REL_W      = RN_W + 1;

	localparam int MTOT_W    = MASS_W + 1;
	localparam int PROD_W    = REL_W + MTOT_W;
	localparam int JQ_W      = 41;
	localparam int J_W       = JQ_W + 1;
	localparam int JREM_W    = PROD_W + 1;
	localparam int JN_W      = J_W + NRM_W;
	localparam int IMP_SHIFT = 32;

	localparam logic [GAP_W-1:0] GAP_RESET = 16'd256;
	localparam logic signed [63:0] FIELD_MAX = (64'sd1 <<< (FIELD_W - 1)) - 64'sd1;
	localparam logic signed [63:0] FIELD_MIN = -(64'sd1 <<< (FIELD_W - 1));

	typedef enum logic [1:0] {
		ST_MISS       = 2'd0,
		ST_HIT        = 2'd1,
		ST_COINCIDENT = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] pos_x;
		logic signed [FIELD_W-1:0] pos_y;
		logic signed [FIELD_W-1:0] vel_x;
		logic signed [FIELD_W-1:0] vel_y;
		logic [RAD_W-1:0]          radius;
		logic [MASS_W-1:0]         mass;
	} disc_t;

	typedef struct packed {
		status_t status;
		disc_t   a;
		disc_t   b;
	} pair_t;

	typedef struct packed {
		pair_t                    pair;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
	} sq_ctx_t;

	typedef struct packed {
		pair_t             pair;
		logic [ROOT_W-1:0] dlen;
		logic              negx;
		logic              negy;
	} nd_ctx_t;

	typedef struct packed {
		pair_t                     pair;
		logic signed [NRM_W-1:0]   nx;
		logic signed [NRM_W-1:0]   ny;
		logic signed [FIELD_W-1:0] p1x;
		logic signed [FIELD_W-1:0] p1y;
		logic signed [FIELD_W-1:0] p2x;
		logic signed [FIELD_W-1:0] p2y;
		logic [MTOT_W-1:0]         mtot;
		logic                      neg1;
		logic                      neg2;
	} jd_ctx_t;

	// round(x / 2^k), ties away from zero
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
			input int unsigned k);
		logic [63:0] mag;
		logic [63:0] q;
		mag = x[63] ? 64'(-x) : 64'(x);
		q = (mag + (64'd1 << (k - 1))) >> k;
		return x[63] ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [FIELD_W-1:0] sat_fld(input logic signed [63:0] x);
		logic signed [63:0] r;
		r = x;
		if (x > FIELD_MAX) r = FIELD_MAX;
		if (x < FIELD_MIN) r = FIELD_MIN;
		return r[FIELD_W-1:0];
	endfunction

endpackage

// ===== hdl/disc_pair_collision_resolver.sv =====
`timescale 1ns / 1ps
// Top level of the disc pair collision resolver: stream ports, gap register, pipeline.
// Depends on dpcr_pkg and dpcr_sqrt.

// One disc pair enters per clock while the pipeline is not held. Each pair passes through
// the difference and squaring stages, the square root (one bit a stage), stage 4 and the
// unit normal divider, the push and relative velocity stages, the impulse divider (one
// quotient bit a stage), and the velocity update and output register stages. The whole
// pipeline holds while an output word waits on m_tready.
// Write separation_gap only while no pair is in flight.
module disc_pair_collision_resolver import dpcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius, first_mass,
	// second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius, second_mass
	input  logic [231:0]      s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y,
	// new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y
	output logic [167:0]      m_tdata,
	// collision_status
	output logic [1:0]        m_tuser,
	input  logic              cfg_wr_en,
	input  logic [GAP_W-1:0]  cfg_wr_data
);

	logic             en;
	logic [GAP_W-1:0] gap_q;
	pair_t            in_pair;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_RESET;
		end else if (cfg_wr_en) begin
			gap_q <= cfg_wr_data;
		end
	end

	always_comb begin
		in_pair          = '0;
		in_pair.status   = ST_MISS;
		in_pair.a.pos_x  = s_tdata[20:0];
		in_pair.a.pos_y  = s_tdata[41:21];
		in_pair.a.vel_x  = s_tdata[62:42];
		in_pair.a.vel_y  = s_tdata[83:63];
		in_pair.a.radius = s_tdata[99:84];
		in_pair.a.mass   = s_tdata[115:100];
		in_pair.b.pos_x  = s_tdata[136:116];
		in_pair.b.pos_y  = s_tdata[157:137];
		in_pair.b.vel_x  = s_tdata[178:158];
		in_pair.b.vel_y  = s_tdata[199:179];
		in_pair.b.radius = s_tdata[215:200];
		in_pair.b.mass   = s_tdata[231:216];
	end

	// ---------------- stages 1..3: differences, squares, overlap test
	logic                     vld_s1, vld_s2, vld_s3;
	pair_t                    pair_s1, pair_s2;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dx_s2, dy_s2;
	logic [SQR_W-2:0]         dxx_s2, dyy_s2;
	logic [RSQ_W-1:0]         rsq_s2;
	logic signed [SQR_W-1:0]  dxx_full, dyy_full;
	logic [RSUM_W-1:0]        rsum_s1;
	logic [D2_W-1:0]          d2;
	logic [SQ_IN_W-1:0]       rad_s3;
	sq_ctx_t                  sqc_s3;

	assign dxx_full = SQR_W'(dx_s1) * SQR_W'(dx_s1);
	assign dyy_full = SQR_W'(dy_s1) * SQR_W'(dy_s1);
	assign d2       = D2_W'(dxx_s2) + D2_W'(dyy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1 <= in_pair;
			dx_s1   <= DIFF_W'(in_pair.b.pos_x) - DIFF_W'(in_pair.a.pos_x);
			dy_s1   <= DIFF_W'(in_pair.b.pos_y) - DIFF_W'(in_pair.a.pos_y);
			rsum_s1 <= RSUM_W'(in_pair.a.radius) + RSUM_W'(in_pair.b.radius);

			pair_s2 <= pair_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			dxx_s2  <= dxx_full[SQR_W-2:0];
			dyy_s2  <= dyy_full[SQR_W-2:0];
			rsq_s2  <= RSQ_W'(rsum_s1) * RSQ_W'(rsum_s1);

			sqc_s3.pair.a <= pair_s2.a;
			sqc_s3.pair.b <= pair_s2.b;
			sqc_s3.dx     <= dx_s2;
			sqc_s3.dy     <= dy_s2;
			rad_s3        <= SQ_IN_W'(d2) << RAD_SCALE;
			priority if (d2 == '0) begin
				sqc_s3.pair.status <= ST_COINCIDENT;
			end else if (d2 >= D2_W'(rsq_s2)) begin
				sqc_s3.pair.status <= ST_MISS;
			end else begin
				sqc_s3.pair.status <= ST_HIT;
			end
		end
	end

	// ---------------- square root: distance = floor(sqrt(d2 * 2^16))
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	sq_ctx_t           sq_ctx;

	dpcr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_rad   (rad_s3),
		.in_ctx   (sqc_s3),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_ctx  (sq_ctx)
	);

	// ---------------- stage 4 and normal divider: n = round(d * 2^24 / distance)
	logic              vld_s4;
	logic [NREM_W-1:0] remx_s4, remy_s4;
	nd_ctx_t           ndc_s4;
	logic [DIFF_W-1:0] magx, magy;

	assign magx = sq_ctx.dx[DIFF_W-1] ? DIFF_W'(-sq_ctx.dx) : DIFF_W'(sq_ctx.dx);
	assign magy = sq_ctx.dy[DIFF_W-1] ? DIFF_W'(-sq_ctx.dy) : DIFF_W'(sq_ctx.dy);

	always_ff @(posedge clk) begin
		if (en) begin
			remx_s4     <= (NREM_W'(magx) << NRM_SHIFT) + NREM_W'(sq_root >> 1);
			remy_s4     <= (NREM_W'(magy) << NRM_SHIFT) + NREM_W'(sq_root >> 1);
			ndc_s4.pair <= sq_ctx.pair;
			ndc_s4.dlen <= sq_root;
			ndc_s4.negx <= sq_ctx.dx[DIFF_W-1];
			ndc_s4.negy <= sq_ctx.dy[DIFF_W-1];
		end
	end

	logic              nd_vld_s  [NQ_W];
	logic [NREM_W-1:0] nd_remx_s [NQ_W];
	logic [NREM_W-1:0] nd_remy_s [NQ_W];
	logic [NQ_W-1:0]   nd_qx_s   [NQ_W];
	logic [NQ_W-1:0]   nd_qy_s   [NQ_W];
	nd_ctx_t           nd_ctx_s  [NQ_W];

	for (genvar i = 0; i < NQ_W; i++) begin : g_ndiv
		localparam int K = NQ_W - 1 - i;
		logic              vld_in;
		logic [NREM_W-1:0] rx_in, ry_in, sub;
		logic [NQ_W-1:0]   qx_in, qy_in;
		nd_ctx_t           ctx_in;

		if (i == 0) begin : g_first
			assign vld_in = vld_s4;
			assign rx_in  = remx_s4;
			assign ry_in  = remy_s4;
			assign qx_in  = '0;
			assign qy_in  = '0;
			assign ctx_in = ndc_s4;
		end else begin : g_next
			assign vld_in = nd_vld_s[i-1];
			assign rx_in  = nd_remx_s[i-1];
			assign ry_in  = nd_remy_s[i-1];
			assign qx_in  = nd_qx_s[i-1];
			assign qy_in  = nd_qy_s[i-1];
			assign ctx_in = nd_ctx_s[i-1];
		end

		assign sub = NREM_W'(ctx_in.dlen) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nd_vld_s[i] <= 1'b0;
			end else if (en) begin
				nd_vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nd_ctx_s[i] <= ctx_in;
				if (rx_in >= sub) begin
					nd_remx_s[i] <= rx_in - sub;
					nd_qx_s[i]   <= qx_in | (NQ_W'(1) << K);
				end else begin
					nd_remx_s[i] <= rx_in;
					nd_qx_s[i]   <= qx_in;
				end
				if (ry_in >= sub) begin
					nd_remy_s[i] <= ry_in - sub;
					nd_qy_s[i]   <= qy_in | (NQ_W'(1) << K);
				end else begin
					nd_remy_s[i] <= ry_in;
					nd_qy_s[i]   <= qy_in;
				end
			end
		end
	end

	// ---------------- stages 5..9: push, relative velocity, new positions, impulse numerators
	logic                      vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	pair_t                     pair_s5, pair_s6, pair_s7, pair_s8;
	logic signed [NRM_W-1:0]   nx_s5, ny_s5, nx_s6, ny_s6, nx_s7, ny_s7, nx_s8, ny_s8;
	logic signed [PUSH_W-1:0]  push_s5;
	logic signed [DIFF_W-1:0]  dvx_s5, dvy_s5;
	logic signed [PN_W-1:0]    pxn_s6, pyn_s6;
	logic signed [RN_W-1:0]    rxn_s6, ryn_s6;
	logic signed [SHIFT_W-1:0] sx_s7, sy_s7;
	logic signed [REL_W-1:0]   rel_s7;
	logic signed [FIELD_W-1:0] p1x_s8, p1y_s8, p2x_s8, p2y_s8;
	logic signed [PROD_W-1:0]  prod1_s8, prod2_s8;
	logic [MTOT_W-1:0]         mtot_s8;
	logic [JREM_W-1:0]         rem1_s9, rem2_s9;
	jd_ctx_t                   jdc_s9;
	nd_ctx_t                   nd_out;
	logic [RSG_W-1:0]          rsg;
	logic signed [63:0]        sxr, syr;
	logic [PROD_W-1:0]         mag1, mag2;

	assign nd_out = nd_ctx_s[NQ_W-1];
	assign rsg    = RSG_W'(nd_out.pair.a.radius) + RSG_W'(nd_out.pair.b.radius) + RSG_W'(gap_q);
	assign sxr    = rnd_shr(64'(pxn_s6), PUSH_SHIFT);
	assign syr    = rnd_shr(64'(pyn_s6), PUSH_SHIFT);
	assign mag1   = prod1_s8[PROD_W-1] ? PROD_W'(-prod1_s8) : PROD_W'(prod1_s8);
	assign mag2   = prod2_s8[PROD_W-1] ? PROD_W'(-prod2_s8) : PROD_W'(prod2_s8);

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s5 <= nd_out.pair;
			nx_s5   <= nd_out.negx ? -NRM_W'(nd_qx_s[NQ_W-1]) : NRM_W'(nd_qx_s[NQ_W-1]);
			ny_s5   <= nd_out.negy ? -NRM_W'(nd_qy_s[NQ_W-1]) : NRM_W'(nd_qy_s[NQ_W-1]);
			push_s5 <= $signed(PUSH_W'(rsg) << PUSH_FRAC) - $signed(PUSH_W'(nd_out.dlen));
			dvx_s5  <= DIFF_W'(nd_out.pair.b.vel_x) - DIFF_W'(nd_out.pair.a.vel_x);
			dvy_s5  <= DIFF_W'(nd_out.pair.b.vel_y) - DIFF_W'(nd_out.pair.a.vel_y);

			pair_s6 <= pair_s5;
			nx_s6   <= nx_s5;
			ny_s6   <= ny_s5;
			pxn_s6  <= PN_W'(push_s5) * PN_W'(nx_s5);
			pyn_s6  <= PN_W'(push_s5) * PN_W'(ny_s5);
			rxn_s6  <= RN_W'(dvx_s5) * RN_W'(nx_s5);
			ryn_s6  <= RN_W'(dvy_s5) * RN_W'(ny_s5);

			pair_s7 <= pair_s6;
			nx_s7   <= nx_s6;
			ny_s7   <= ny_s6;
			sx_s7   <= sxr[SHIFT_W-1:0];
			sy_s7   <= syr[SHIFT_W-1:0];
			rel_s7  <= REL_W'(rxn_s6) + REL_W'(ryn_s6);

			pair_s8  <= pair_s7;
			nx_s8    <= nx_s7;
			ny_s8    <= ny_s7;
			p1x_s8   <= sat_fld(64'(pair_s7.a.pos_x) - 64'(sx_s7));
			p1y_s8   <= sat_fld(64'(pair_s7.a.pos_y) - 64'(sy_s7));
			p2x_s8   <= sat_fld(64'(pair_s7.b.pos_x) + 64'(sx_s7));
			p2y_s8   <= sat_fld(64'(pair_s7.b.pos_y) + 64'(sy_s7));
			prod1_s8 <= PROD_W'($signed({1'b0, pair_s7.b.mass, 1'b0})) * PROD_W'(rel_s7);
			prod2_s8 <= PROD_W'($signed({1'b0, pair_s7.a.mass, 1'b0})) * PROD_W'(rel_s7);
			mtot_s8  <= MTOT_W'(pair_s7.a.mass) + MTOT_W'(pair_s7.b.mass);

			rem1_s9     <= JREM_W'(mag1) + JREM_W'(mtot_s8 >> 1);
			rem2_s9     <= JREM_W'(mag2) + JREM_W'(mtot_s8 >> 1);
			jdc_s9.pair <= pair_s8;
			jdc_s9.nx   <= nx_s8;
			jdc_s9.ny   <= ny_s8;
			jdc_s9.p1x  <= p1x_s8;
			jdc_s9.p1y  <= p1y_s8;
			jdc_s9.p2x  <= p2x_s8;
			jdc_s9.p2y  <= p2y_s8;
			jdc_s9.mtot <= mtot_s8;
			jdc_s9.neg1 <= prod1_s8[PROD_W-1];
			jdc_s9.neg2 <= prod2_s8[PROD_W-1];
		end
	end

	// ---------------- impulse divider: j = round(2 * m * rel / (m1 + m2))
	logic              jd_vld_s [JQ_W];
	logic [JREM_W-1:0] jd_r1_s  [JQ_W];
	logic [JREM_W-1:0] jd_r2_s  [JQ_W];
	logic [JQ_W-1:0]   jd_q1_s  [JQ_W];
	logic [JQ_W-1:0]   jd_q2_s  [JQ_W];
	jd_ctx_t           jd_ctx_s [JQ_W];

	for (genvar i = 0; i < JQ_W; i++) begin : g_jdiv
		localparam int K = JQ_W - 1 - i;
		logic              vld_in;
		logic [JREM_W-1:0] r1_in, r2_in, sub;
		logic [JQ_W-1:0]   q1_in, q2_in;
		jd_ctx_t           ctx_in;

		if (i == 0) begin : g_first
			assign vld_in = vld_s9;
			assign r1_in  = rem1_s9;
			assign r2_in  = rem2_s9;
			assign q1_in  = '0;
			assign q2_in  = '0;
			assign ctx_in = jdc_s9;
		end else begin : g_next
			assign vld_in = jd_vld_s[i-1];
			assign r1_in  = jd_r1_s[i-1];
			assign r2_in  = jd_r2_s[i-1];
			assign q1_in  = jd_q1_s[i-1];
			assign q2_in  = jd_q2_s[i-1];
			assign ctx_in = jd_ctx_s[i-1];
		end

		assign sub = JREM_W'(ctx_in.mtot) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				jd_vld_s[i] <= 1'b0;
			end else if (en) begin
				jd_vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				jd_ctx_s[i] <= ctx_in;
				if (r1_in >= sub) begin
					jd_r1_s[i] <= r1_in - sub;
					jd_q1_s[i] <= q1_in | (JQ_W'(1) << K);
				end else begin
					jd_r1_s[i] <= r1_in;
					jd_q1_s[i] <= q1_in;
				end
				if (r2_in >= sub) begin
					jd_r2_s[i] <= r2_in - sub;
					jd_q2_s[i] <= q2_in | (JQ_W'(1) << K);
				end else begin
					jd_r2_s[i] <= r2_in;
					jd_q2_s[i] <= q2_in;
				end
			end
		end
	end

	// ---------------- stages 10..12: impulse along the normal, velocity update, output
	logic                      vld_s10, vld_s11, vld_s12;
	jd_ctx_t                   jdc_s10, jdc_s11, jd_out;
	logic signed [J_W-1:0]     j1_s10, j2_s10;
	logic signed [JN_W-1:0]    j1nx_s11, j1ny_s11, j2nx_s11, j2ny_s11;
	logic [167:0]              data_s12;
	status_t                   status_s12;
	logic [167:0]              data_nxt;
	logic signed [FIELD_W-1:0] v1x, v1y, v2x, v2y;

	assign jd_out = jd_ctx_s[JQ_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			jdc_s10 <= jd_out;
			j1_s10  <= jd_out.neg1 ? -J_W'(jd_q1_s[JQ_W-1]) : J_W'(jd_q1_s[JQ_W-1]);
			j2_s10  <= jd_out.neg2 ? -J_W'(jd_q2_s[JQ_W-1]) : J_W'(jd_q2_s[JQ_W-1]);

			jdc_s11  <= jdc_s10;
			j1nx_s11 <= JN_W'(j1_s10) * JN_W'(jdc_s10.nx);
			j1ny_s11 <= JN_W'(j1_s10) * JN_W'(jdc_s10.ny);
			j2nx_s11 <= JN_W'(j2_s10) * JN_W'(jdc_s10.nx);
			j2ny_s11 <= JN_W'(j2_s10) * JN_W'(jdc_s10.ny);

			data_s12   <= data_nxt;
			status_s12 <= jdc_s11.pair.status;
		end
	end

	always_comb begin
		// velocities pass through when both masses are zero
		if (jdc_s11.mtot == '0) begin
			v1x = jdc_s11.pair.a.vel_x;
			v1y = jdc_s11.pair.a.vel_y;
			v2x = jdc_s11.pair.b.vel_x;
			v2y = jdc_s11.pair.b.vel_y;
		end else begin
			v1x = sat_fld(64'(jdc_s11.pair.a.vel_x) + rnd_shr(64'(j1nx_s11), IMP_SHIFT));
			v1y = sat_fld(64'(jdc_s11.pair.a.vel_y) + rnd_shr(64'(j1ny_s11), IMP_SHIFT));
			v2x = sat_fld(64'(jdc_s11.pair.b.vel_x) - rnd_shr(64'(j2nx_s11), IMP_SHIFT));
			v2y = sat_fld(64'(jdc_s11.pair.b.vel_y) - rnd_shr(64'(j2ny_s11), IMP_SHIFT));
		end
		if (jdc_s11.pair.status == ST_HIT) begin
			data_nxt = {v2y, v2x, jdc_s11.p2y, jdc_s11.p2x,
			            v1y, v1x, jdc_s11.p1y, jdc_s11.p1x};
		end else begin
			data_nxt = {jdc_s11.pair.b.vel_y, jdc_s11.pair.b.vel_x,
			            jdc_s11.pair.b.pos_y, jdc_s11.pair.b.pos_x,
			            jdc_s11.pair.a.vel_y, jdc_s11.pair.a.vel_x,
			            jdc_s11.pair.a.pos_y, jdc_s11.pair.a.pos_x};
		end
	end

	// valid bits travel with the data; hold everything while the output word waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= sq_vld;
			vld_s5  <= nd_vld_s[NQ_W-1];
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= jd_vld_s[JQ_W-1];
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	assign m_tvalid = vld_s12;
	assign m_tdata  = data_s12;
	assign m_tuser  = status_s12;

`ifndef SYNTHESIS
	// the unit normal never exceeds one in any component
	a_norm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && pair_s5.status == ST_HIT |->
			nx_s5 <= 18'sd65536 && nx_s5 >= -18'sd65536 &&
			ny_s5 <= 18'sd65536 && ny_s5 >= -18'sd65536)
		else $error("normal component out of range");

	// overlapping discs always get pushed apart
	a_push_pos: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && pair_s5.status == ST_HIT |-> push_s5 > 0)
		else $error("push distance not positive on a hit");

	// a held pipeline keeps its valid pattern
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s6) && $stable(vld_s10) && $stable(jd_vld_s[0]))
		else $error("pipeline moved during a stall");
`endif

endmodule

// ===== hdl/dpcr_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with a side payload.
// Depends on dpcr_pkg.
module dpcr_sqrt import dpcr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [SQ_IN_W-1:0]  in_rad,
	input  sq_ctx_t             in_ctx,
	output logic                out_vld,
	output logic [ROOT_W-1:0]   out_root,
	output sq_ctx_t             out_ctx
);

	logic                vld_s  [ROOT_W];
	logic [SQ_REM_W-1:0] rem_s  [ROOT_W];
	logic [ROOT_W-1:0]   root_s [ROOT_W];
	sq_ctx_t             ctx_s  [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		localparam int K = ROOT_W - 1 - i;
		logic                vld_in;
		logic [SQ_REM_W-1:0] rem_in;
		logic [SQ_REM_W-1:0] trial;
		logic [ROOT_W-1:0]   root_in;
		sq_ctx_t             ctx_in;

		if (i == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = SQ_REM_W'(in_rad);
			assign root_in = '0;
			assign ctx_in  = in_ctx;
		end else begin : g_next
			assign vld_in  = vld_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign ctx_in  = ctx_s[i-1];
		end

		// (root + 2^K)^2 - root^2
		assign trial = (SQ_REM_W'(root_in) << (K + 1)) + (SQ_REM_W'(1) << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[i] <= ctx_in;
				if (rem_in >= trial) begin
					rem_s[i]  <= rem_in - trial;
					root_s[i] <= root_in | (ROOT_W'(1) << K);
				end else begin
					rem_s[i]  <= rem_in;
					root_s[i] <= root_in;
				end
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W-1];
	assign out_root = root_s[ROOT_W-1];
	assign out_ctx  = ctx_s[ROOT_W-1];

endmodule
